/* src/cau_pkg.sv */
package cau_pkg;

  // default field format, signed Q16.16
  localparam int FIELD_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // operation codes carried on the mode field
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_MUL    = 2'd1;
  localparam logic [1:0] MODE_DIV    = 2'd2;
  // no operation, gives a zero result with both flags clear
  localparam logic [1:0] MODE_UNUSED = 2'd3;

endpackage

/* src/complex_arith_unit.sv */
// channel   direction  handshake                     payload
// operand   in         operand_valid / operand_stall mode, a_real, a_imag, b_real, b_imag
// result    out        result_valid / result_stall   res_real, res_imag, zero_divisor,
//                                                    overflowed
//
// one beat accepted per cycle when unstalled
// the divide path is a bit-per-stage restoring divider
// rst is synchronous, active high, and empties every stage and the skid
// a stalled result parks in a one-beat skid; operand_stall rises only
// while the skid holds a beat, and the whole pipe then holds still
module complex_arith_unit #(
  parameter int FIELD_WIDTH   = cau_pkg::FIELD_WIDTH_DEF,
  parameter int FRACTION_BITS = cau_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          operand_valid,
  output logic                          operand_stall,
  input  logic [1:0]                    mode,
  input  logic signed [FIELD_WIDTH-1:0] a_real,
  input  logic signed [FIELD_WIDTH-1:0] a_imag,
  input  logic signed [FIELD_WIDTH-1:0] b_real,
  input  logic signed [FIELD_WIDTH-1:0] b_imag,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [FIELD_WIDTH-1:0] res_real,
  output logic signed [FIELD_WIDTH-1:0] res_imag,
  output logic                          zero_divisor,
  output logic                          overflowed
);

  localparam int W  = FIELD_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int NS = W + 2;

  // beat details that ride alongside the divider
  typedef struct packed {
    logic [1:0]   mode;
    logic         neg_re;
    logic         neg_im;
    logic [W-1:0] alt_re;
    logic [W-1:0] alt_im;
    logic         alt_ov;
  } side_t;

  // clamp a magnitude to the field range and apply the sign; msb is the overflow flag
  function automatic logic [W:0] sat_fn(input logic neg, input logic [2*W-1:0] m);
    logic [2*W-1:0] lim;
    logic [2*W-1:0] val;
    logic           ov;
    lim = neg ? ((2*W)'(1) << (W - 1)) : (((2*W)'(1) << (W - 1)) - (2*W)'(1));
    ov  = (m > lim);
    val = ov ? lim : m;
    return {ov, neg ? (~val[W-1:0] + W'(1)) : val[W-1:0]};
  endfunction

  // whole pipe moves unless a beat is parked in the skid
  logic skid_full;
  logic en;
  logic accept;

  assign en            = !skid_full;
  assign operand_stall = skid_full;
  assign accept        = operand_valid && !skid_full;

  // stage 0: operand capture
  logic                v0;
  logic [1:0]          m0;
  logic signed [W-1:0] ar0, ai0, br0, bi0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0  <= mode;
      ar0 <= a_real;
      ai0 <= a_imag;
      br0 <= b_real;
      bi0 <= b_imag;
    end
  end

  // stage 1: the six part products and the plain sums
  logic                  v1;
  logic [1:0]            m1;
  logic signed [2*W-1:0] p_rr, p_ii, p_ir, p_ri, d_r, d_i;
  logic signed [W:0]     s_re1, s_im1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1    <= m0;
      p_rr  <= ar0 * br0;
      p_ii  <= ai0 * bi0;
      p_ir  <= ai0 * br0;
      p_ri  <= ar0 * bi0;
      d_r   <= br0 * br0;
      d_i   <= bi0 * bi0;
      s_re1 <= (W+1)'(ar0) + (W+1)'(br0);
      s_im1 <= (W+1)'(ai0) + (W+1)'(bi0);
    end
  end

  // stage 2: numerators and |b|^2
  logic                v2;
  logic [1:0]          m2;
  logic signed [2*W:0] n_re2, n_im2;
  logic [2*W-1:0]      den2;
  logic signed [W:0]   s_re2, s_im2;
  logic signed [2*W:0] e_rr, e_ii, e_ir, e_ri;

  assign e_rr = (2*W+1)'(p_rr);
  assign e_ii = (2*W+1)'(p_ii);
  assign e_ir = (2*W+1)'(p_ir);
  assign e_ri = (2*W+1)'(p_ri);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2    <= m1;
      s_re2 <= s_re1;
      s_im2 <= s_im1;
      den2  <= $unsigned(d_r) + $unsigned(d_i);
      case (m1)
        cau_pkg::MODE_MUL: begin
          n_re2 <= e_rr - e_ii;
          n_im2 <= e_ir + e_ri;
        end
        cau_pkg::MODE_DIV: begin
          // a times the conjugate of b
          n_re2 <= e_rr + e_ii;
          n_im2 <= e_ir - e_ri;
        end
        default: begin
          n_re2 <= '0;
          n_im2 <= '0;
        end
      endcase
    end
  end

  // stage 3: sign and magnitude, saturated add result
  logic           v3;
  logic [1:0]     m3;
  logic           neg_re3, neg_im3;
  logic [2*W-1:0] mag_re3, mag_im3, den3;
  logic [W-1:0]   add_re3, add_im3;
  logic           add_ov3;
  logic [2*W:0]   abs_re2, abs_im2;
  logic           aov_re, aov_im;

  assign abs_re2 = n_re2[2*W] ? (~n_re2 + (2*W+1)'(1)) : n_re2;
  assign abs_im2 = n_im2[2*W] ? (~n_im2 + (2*W+1)'(1)) : n_im2;
  assign aov_re  = s_re2[W] != s_re2[W-1];
  assign aov_im  = s_im2[W] != s_im2[W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3      <= m2;
      neg_re3 <= n_re2[2*W];
      neg_im3 <= n_im2[2*W];
      mag_re3 <= abs_re2[2*W-1:0];
      mag_im3 <= abs_im2[2*W-1:0];
      den3    <= den2;
      // an add overflows only by one bit, so the sign bit picks the bound
      add_re3 <= aov_re ? {s_re2[W], {(W-1){!s_re2[W]}}} : s_re2[W-1:0];
      add_im3 <= aov_im ? {s_im2[W], {(W-1){!s_im2[W]}}} : s_im2[W-1:0];
      add_ov3 <= aov_re || aov_im;
    end
  end

  // multiply rounding: half an lsb on the magnitude, then drop the fraction
  logic [2*W-1:0] half;
  logic [2*W-1:0] mr_re, mr_im;
  logic [W:0]     ms_re, ms_im;
  side_t          side_in;

  assign half  = ((2*W)'(1) << F) >> 1;
  assign mr_re = (mag_re3 + half) >> F;
  assign mr_im = (mag_im3 + half) >> F;
  assign ms_re = sat_fn(neg_re3, mr_re);
  assign ms_im = sat_fn(neg_im3, mr_im);

  always_comb begin
    side_in.mode   = m3;
    side_in.neg_re = neg_re3;
    side_in.neg_im = neg_im3;
    case (m3)
      cau_pkg::MODE_ADD: begin
        side_in.alt_re = add_re3;
        side_in.alt_im = add_im3;
        side_in.alt_ov = add_ov3;
      end
      cau_pkg::MODE_MUL: begin
        side_in.alt_re = ms_re[W-1:0];
        side_in.alt_im = ms_im[W-1:0];
        side_in.alt_ov = ms_re[W] || ms_im[W];
      end
      default: begin
        side_in.alt_re = '0;
        side_in.alt_im = '0;
        side_in.alt_ov = 1'b0;
      end
    endcase
  end

  // divider and the matching side line
  logic       dv_valid;
  logic [W:0] q_re, q_im;
  logic       ovf_re, ovf_im, dz;
  side_t      sb [NS];

  cau_divider #(
    .W(W),
    .F(F)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .num_re   (mag_re3),
    .num_im   (mag_im3),
    .den      (den3),
    .out_valid(dv_valid),
    .q_re     (q_re),
    .q_im     (q_im),
    .ovf_re   (ovf_re),
    .ovf_im   (ovf_im),
    .dz       (dz)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= side_in;
      for (int k = 1; k < NS; k++) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  // final rounding of the quotient: one extra bit, add one, halve
  logic [W+1:0]   qp_re, qp_im;
  logic [2*W-1:0] qm_re, qm_im;
  logic [W:0]     ds_re, ds_im;
  logic [W-1:0]   fin_re, fin_im;
  logic           fin_dz, fin_ov;
  side_t          sl;

  assign sl    = sb[NS-1];
  assign qp_re = ({1'b0, q_re} + (W+2)'(1)) >> 1;
  assign qp_im = ({1'b0, q_im} + (W+2)'(1)) >> 1;
  assign qm_re = ovf_re ? '1 : (2*W)'(qp_re);
  assign qm_im = ovf_im ? '1 : (2*W)'(qp_im);
  assign ds_re = sat_fn(sl.neg_re, qm_re);
  assign ds_im = sat_fn(sl.neg_im, qm_im);

  always_comb begin
    if (sl.mode == cau_pkg::MODE_DIV) begin
      if (dz) begin
        // divide by zero gives zero and only the divisor flag
        fin_re = '0;
        fin_im = '0;
        fin_dz = 1'b1;
        fin_ov = 1'b0;
      end else begin
        fin_re = ds_re[W-1:0];
        fin_im = ds_im[W-1:0];
        fin_dz = 1'b0;
        fin_ov = ds_re[W] || ds_im[W];
      end
    end else begin
      fin_re = sl.alt_re;
      fin_im = sl.alt_im;
      fin_dz = 1'b0;
      fin_ov = sl.alt_ov;
    end
  end

  // output register and one-beat skid
  logic [W-1:0] sk_re, sk_im;
  logic         sk_dz, sk_ov;
  logic         out_free;

  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else if (out_free) begin
      if (skid_full) begin
        result_valid <= 1'b1;
        skid_full    <= 1'b0;
      end else begin
        result_valid <= dv_valid;
      end
    end else if (dv_valid) begin
      // if the skid was empty, en is high and this beat parks in the skid
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_full) begin
        res_real     <= sk_re;
        res_imag     <= sk_im;
        zero_divisor <= sk_dz;
        overflowed   <= sk_ov;
      end else begin
        res_real     <= fin_re;
        res_imag     <= fin_im;
        zero_divisor <= fin_dz;
        overflowed   <= fin_ov;
      end
    end else if (en) begin
      sk_re <= fin_re;
      sk_im <= fin_im;
      sk_dz <= fin_dz;
      sk_ov <= fin_ov;
    end
  end

`ifndef SYNTHESIS
  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> result_valid)
    else $error("skid holds a beat while the output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(result_valid && result_stall))
    else $error("skid filled while the output was free");

  a_flags_apart: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(zero_divisor && overflowed))
    else $error("divide by zero also flagged overflow");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && zero_divisor) |-> (res_real == '0 && res_imag == '0))
    else $error("divide by zero gave a non-zero result");
`endif

endmodule

/* src/cau_divider.sv */
module cau_divider #(
  parameter int W = cau_pkg::FIELD_WIDTH_DEF,
  parameter int F = cau_pkg::FRACTION_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [2*W-1:0] num_re,
  input  logic [2*W-1:0] num_im,
  input  logic [2*W-1:0] den,
  output logic           out_valid,
  output logic [W:0]     q_re,
  output logic [W:0]     q_im,
  output logic           ovf_re,
  output logic           ovf_im,
  output logic           dz
);

  localparam int RW = 3*W + F + 2;
  localparam int NS = W + 2;

  logic           v      [NS];
  logic [RW-1:0]  rem_re [NS];
  logic [RW-1:0]  rem_im [NS];
  logic [W:0]     qr     [NS];
  logic [W:0]     qi     [NS];
  logic           ofr    [NS];
  logic           ofi    [NS];
  logic           zr     [NS];
  logic [2*W-1:0] dn     [NS];

  logic [RW-1:0] n_re_w, n_im_w, d_w;

  // quotient limited to W+1 bits, anything larger saturates anyway
  assign n_re_w = RW'(num_re) << (F + 1);
  assign n_im_w = RW'(num_im) << (F + 1);
  assign d_w    = RW'(den) << (W + 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_re[0] <= n_re_w;
      rem_im[0] <= n_im_w;
      qr[0]     <= '0;
      qi[0]     <= '0;
      ofr[0]    <= (n_re_w >= d_w);
      ofi[0]    <= (n_im_w >= d_w);
      zr[0]     <= (den == '0);
      dn[0]     <= den;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    localparam int I = W + 1 - k;
    logic [RW:0] dsh;
    logic [RW:0] tr_re, tr_im;

    assign dsh   = {1'b0, RW'(dn[k-1]) << I};
    assign tr_re = {1'b0, rem_re[k-1]} - dsh;
    assign tr_im = {1'b0, rem_im[k-1]} - dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_re[k] <= tr_re[RW] ? rem_re[k-1] : tr_re[RW-1:0];
        rem_im[k] <= tr_im[RW] ? rem_im[k-1] : tr_im[RW-1:0];
        qr[k]     <= qr[k-1] | ((W+1)'(!tr_re[RW]) << I);
        qi[k]     <= qi[k-1] | ((W+1)'(!tr_im[RW]) << I);
        ofr[k]    <= ofr[k-1];
        ofi[k]    <= ofi[k-1];
        zr[k]     <= zr[k-1];
        dn[k]     <= dn[k-1];
      end
    end
  end

  assign out_valid = v[NS-1];
  assign q_re      = qr[NS-1];
  assign q_im      = qi[NS-1];
  assign ovf_re    = ofr[NS-1];
  assign ovf_im    = ofi[NS-1];
  assign dz        = zr[NS-1];

endmodule

/* sim/cau_checker.sv */
`timescale 1ns / 1ps

module cau_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        operand_valid,
  input  logic        operand_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] a_real,
  input  logic [31:0] a_imag,
  input  logic [31:0] b_real,
  input  logic [31:0] b_imag,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [31:0] res_real,
  input  logic [31:0] res_imag,
  input  logic        zero_divisor,
  input  logic        overflowed,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        dz;
    logic        ov;
  } cplx_res_t;

  cplx_res_t result_q[$];

  // clamp a sign/magnitude value to the field, bit 32 is the overflow flag
  function automatic logic [32:0] clamp_part(input logic neg, input logic [191:0] mag);
    logic [191:0] lim;
    logic         ov;
    lim = neg ? 192'h8000_0000 : 192'h7fff_ffff;
    ov  = 1'b0;
    if (mag > lim) begin
      mag = lim;
      ov  = 1'b1;
    end
    return {ov, neg ? -mag[31:0] : mag[31:0]};
  endfunction

  function automatic cplx_res_t complex_result(input logic [1:0] op, input logic [31:0] ar,
                                               input logic [31:0] ai, input logic [31:0] br,
                                               input logic [31:0] bi);
    logic signed [127:0] xr, xi, yr, yi, nre, nim, den;
    logic [191:0]        mre, mim;
    logic [32:0]         pr, pi;
    cplx_res_t           r;
    xr = signed'(ar);
    xi = signed'(ai);
    yr = signed'(br);
    yi = signed'(bi);
    r  = '0;
    nre = 0;
    nim = 0;
    den = yr * yr + yi * yi;
    case (op)
      cau_pkg::MODE_ADD: begin
        nre = xr + yr;
        nim = xi + yi;
      end
      cau_pkg::MODE_MUL: begin
        nre = xr * yr - xi * yi;
        nim = xi * yr + xr * yi;
      end
      cau_pkg::MODE_DIV: begin
        nre = xr * yr + xi * yi;
        nim = xi * yr - xr * yi;
      end
      default: ;
    endcase
    mre = nre < 0 ? 192'(-nre) : 192'(nre);
    mim = nim < 0 ? 192'(-nim) : 192'(nim);
    if (op == cau_pkg::MODE_MUL) begin
      // round to nearest on the magnitude, ties away from zero
      mre = (mre + 192'h8000) >> 16;
      mim = (mim + 192'h8000) >> 16;
    end else if (op == cau_pkg::MODE_DIV) begin
      if (den == 0) begin
        mre  = 0;
        mim  = 0;
        r.dz = 1'b1;
      end else begin
        mre = ((mre << 17) / 192'(den) + 1) >> 1;
        mim = ((mim << 17) / 192'(den) + 1) >> 1;
      end
    end
    pr   = clamp_part(nre < 0, mre);
    pi   = clamp_part(nim < 0, mim);
    r.re = pr[31:0];
    r.im = pi[31:0];
    r.ov = pr[32] | pi[32];
    return r;
  endfunction

  always @(posedge clk) begin
    cplx_res_t want;
    if (rst) begin
      fails   = 0;
      pending <= 0;
    end else begin
      if (operand_valid && !operand_stall)
        result_q.push_back(complex_result(mode, a_real, a_imag, b_real, b_imag));
      if (result_valid && !result_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result beat re=%h im=%h", $time, res_real, res_imag);
          fails = fails + 1;
        end else begin
          want = result_q.pop_front();
          if (want.re !== res_real) begin
            $display("%0t: res_real expected %h actual %h", $time, want.re, res_real);
            fails = fails + 1;
          end
          if (want.im !== res_imag) begin
            $display("%0t: res_imag expected %h actual %h", $time, want.im, res_imag);
            fails = fails + 1;
          end
          if (want.dz !== zero_divisor) begin
            $display("%0t: zero_divisor expected %b actual %b", $time, want.dz, zero_divisor);
            fails = fails + 1;
          end
          if (want.ov !== overflowed) begin
            $display("%0t: overflowed expected %b actual %b", $time, want.ov, overflowed);
            fails = fails + 1;
          end
        end
      end
      pending <= result_q.size();
    end
  end
endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        operand_valid = 1'b0;
  logic        operand_stall;
  logic [1:0]  mode = cau_pkg::MODE_ADD;
  logic [31:0] a_real = '0;
  logic [31:0] a_imag = '0;
  logic [31:0] b_real = '0;
  logic [31:0] b_imag = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [31:0] res_real;
  logic [31:0] res_imag;
  logic        zero_divisor;
  logic        overflowed;
  int          fails;
  int          pending;
  bit          quiet = 1'b0;   // no idling on either side while set
  int          stall_left = 0;

  always #5 clk = ~clk;

  complex_arith_unit u_dut (
    .clk(clk), .rst(rst),
    .operand_valid(operand_valid), .operand_stall(operand_stall),
    .mode(mode), .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
    .result_valid(result_valid), .result_stall(result_stall),
    .res_real(res_real), .res_imag(res_imag),
    .zero_divisor(zero_divisor), .overflowed(overflowed)
  );

  cau_checker u_checker (
    .clk(clk), .rst(rst),
    .operand_valid(operand_valid), .operand_stall(operand_stall),
    .mode(mode), .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
    .result_valid(result_valid), .result_stall(result_stall),
    .res_real(res_real), .res_imag(res_imag),
    .zero_divisor(zero_divisor), .overflowed(overflowed),
    .fails(fails), .pending(pending)
  );

  // receiver: after each accepted beat, hold stall for a drawn number of cycles
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else begin
      result_stall <= 1'b0;
      if (result_valid && !result_stall)
        stall_left <= quiet ? 0 : $urandom_range(0, 18);
    end
  end

  // one operand beat: idle gap, then hold until accepted
  task automatic send_beat(input logic [1:0] op, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      operand_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operand_valid <= 1'b1;
    mode   <= op;
    a_real <= ar;
    a_imag <= ai;
    b_real <= br;
    b_imag <= bi;
    do @(posedge clk); while (operand_stall);
  endtask

  // mix of full range, small values and the field extremes
  function automatic logic [31:0] pick_part();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return 32'($signed($urandom_range(0, 8191)) - 4096);
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) << $urandom_range(0, 12);
      4: case ($urandom_range(0, 3))
           0: return 32'h8000_0000;
           1: return 32'h7fff_ffff;
           2: return 32'h0;
           default: return 32'hffff_ffff;
         endcase
      default: return 32'h0001_0000 * ($urandom_range(0, 6) - 3);
    endcase
  endfunction

  initial begin
    logic [1:0]  op;
    logic [31:0] br, bi;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every mode, rounding ties, negative zero, zero divisor
    send_beat(cau_pkg::MODE_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(cau_pkg::MODE_ADD, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_beat(cau_pkg::MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_beat(cau_pkg::MODE_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(cau_pkg::MODE_MUL, 32'h0000_8000, 32'h0, 32'h0000_0001, 32'h0);
    send_beat(cau_pkg::MODE_MUL, 32'hffff_8000, 32'h0, 32'h0000_0001, 32'h0);
    send_beat(cau_pkg::MODE_MUL, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    send_beat(cau_pkg::MODE_MUL, 32'h0002_0000, 32'hfffe_0000, 32'h0001_8000, 32'h0000_4000);
    send_beat(cau_pkg::MODE_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
    send_beat(cau_pkg::MODE_DIV, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0);
    send_beat(cau_pkg::MODE_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_beat(cau_pkg::MODE_DIV, 32'h0000_0001, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff);
    send_beat(cau_pkg::MODE_DIV, 32'hffff_ffff, 32'h0, 32'h0002_0000, 32'h0);
    send_beat(cau_pkg::MODE_DIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hffff_0000);
    send_beat(cau_pkg::MODE_UNUSED, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0);
    send_beat(cau_pkg::MODE_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    operand_valid <= 1'b0;

    // drain fully before the random part
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < 1000; i++) begin
      if (i % 150 == 0) quiet = ($urandom_range(0, 2) == 0);
      op = ($urandom_range(0, 15) == 0) ? cau_pkg::MODE_UNUSED : 2'($urandom_range(0, 2));
      br = pick_part();
      bi = pick_part();
      if (op == cau_pkg::MODE_DIV && $urandom_range(0, 9) == 0) begin
        br = '0;
        bi = '0;
      end
      send_beat(op, pick_part(), pick_part(), br, bi);
    end
    operand_valid <= 1'b0;
    quiet = 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fails == 0)
      $display("PASS complex_arith_unit");
    else
      $display("FAIL complex_arith_unit");
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL complex_arith_unit");
    $finish;
  end
endmodule
